// ----- design/olt_pkg.sv -----
// shared types, codes and transition tables for the order lifecycle table
package olt_pkg;

	localparam int ORDER_SLOTS = 256;
	localparam int SLOT_W      = $clog2(ORDER_SLOTS);
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;

	localparam logic [31:0] SUBMIT_TIMEOUT_RESET = 32'd5000;
	localparam logic [31:0] CANCEL_TIMEOUT_RESET = 32'd5000;

	typedef enum logic [3:0] {
		M_CREATE     = 4'd0,
		M_SUBMIT     = 4'd1,
		M_ACK        = 4'd2,
		M_PARTIAL    = 4'd3,
		M_FILL       = 4'd4,
		M_CANCEL_REQ = 4'd5,
		M_CANCEL_CNF = 4'd6,
		M_REJECT     = 4'd7,
		M_EXPIRE     = 4'd8,
		M_ERROR      = 4'd9,
		M_FILL_UPD   = 4'd10,
		M_TIMEOUT    = 4'd11,
		M_EXTEND     = 4'd12
	} mode_t;

	typedef enum logic [3:0] {
		L_CREATED   = 4'd0,
		L_PEND_SUB  = 4'd1,
		L_SUBMITTED = 4'd2,
		L_ACKED     = 4'd3,
		L_PARTIAL   = 4'd4,
		L_FILLED    = 4'd5,
		L_PEND_CAN  = 4'd6,
		L_CANCELLED = 4'd7,
		L_REJECTED  = 4'd8,
		L_EXPIRED   = 4'd9,
		L_ERROR     = 4'd10
	} life_t;

	typedef enum logic [1:0] {
		S_CHANGED   = 2'd0,
		S_NO_CHANGE = 2'd1,
		S_REFUSED   = 2'd2,
		S_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SUBMIT_TIMEOUT = 1'd0,
		CFG_CANCEL_TIMEOUT = 1'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [7:0]  slot;
		logic [31:0] lot_count;
		logic [31:0] now_ms;
		logic [63:0] venue_id;
		logic [31:0] extra_ms;
	} in_item_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] status;
		logic [3:0] state_before;
		logic [3:0] state_after;
		logic       timed_out;
	} result_t;

	typedef struct packed {
		logic [3:0]  life_state;
		logic [31:0] ordered_lots;
		logic [31:0] filled_lots;
		logic [63:0] venue_order;
		logic [31:0] submit_limit;
		logic [31:0] cancel_limit;
		logic [31:0] changed_at;
	} entry_t;

	// write-back request from the update logic
	typedef struct packed {
		logic    we;
		logic    set_used;
		entry_t  wentry;
		result_t res;
	} upd_t;

	typedef struct packed {
		logic  gate;
		life_t nxt;
	} ev_out_t;

	function automatic logic [15:0] bit_of(life_t s);
		return 16'(1) << s;
	endfunction

	function automatic logic is_active(life_t s);
		return s == L_PEND_SUB || s == L_SUBMITTED || s == L_ACKED ||
			s == L_PARTIAL || s == L_PEND_CAN;
	endfunction

	function automatic logic is_terminal(life_t s);
		return s == L_FILLED || s == L_CANCELLED || s == L_REJECTED ||
			s == L_EXPIRED || s == L_ERROR;
	endfunction

	// bit t set when from -> t is allowed
	function automatic logic [15:0] allowed_mask(life_t from);
		logic [15:0] m;
		m = '0;
		case (from)
			L_CREATED:   m = bit_of(L_PEND_SUB) | bit_of(L_ERROR);
			L_PEND_SUB:  m = bit_of(L_SUBMITTED) | bit_of(L_REJECTED) | bit_of(L_ERROR) |
				bit_of(L_EXPIRED);
			L_SUBMITTED: m = bit_of(L_ACKED) | bit_of(L_PARTIAL) | bit_of(L_FILLED) |
				bit_of(L_PEND_CAN) | bit_of(L_CANCELLED) | bit_of(L_REJECTED) |
				bit_of(L_ERROR) | bit_of(L_EXPIRED);
			L_ACKED:     m = bit_of(L_PARTIAL) | bit_of(L_FILLED) | bit_of(L_PEND_CAN) |
				bit_of(L_CANCELLED) | bit_of(L_ERROR) | bit_of(L_EXPIRED);
			L_PARTIAL:   m = bit_of(L_FILLED) | bit_of(L_PEND_CAN) | bit_of(L_CANCELLED) |
				bit_of(L_ERROR) | bit_of(L_EXPIRED);
			L_PEND_CAN:  m = bit_of(L_CANCELLED) | bit_of(L_FILLED) | bit_of(L_ERROR);
			default:     m = '0;
		endcase
		return m;
	endfunction

	// state gate of one lifecycle event
	function automatic ev_out_t event_gate(life_t cur, mode_t ev);
		ev_out_t r;
		r.gate = 1'b0;
		r.nxt  = cur;
		case (ev)
			M_SUBMIT:     if (cur == L_CREATED) begin
				r.nxt = L_PEND_SUB; r.gate = 1'b1;
			end
			M_ACK:        if (cur == L_PEND_SUB) begin
				r.nxt = L_SUBMITTED; r.gate = 1'b1;
			end
			M_PARTIAL:    if (cur == L_SUBMITTED || cur == L_PARTIAL) begin
				r.nxt = L_PARTIAL; r.gate = 1'b1;
			end
			M_FILL:       if (is_active(cur)) begin
				r.nxt = L_FILLED; r.gate = 1'b1;
			end
			M_CANCEL_REQ: if (is_active(cur)) begin
				r.nxt = L_PEND_CAN; r.gate = 1'b1;
			end
			M_CANCEL_CNF: if (cur == L_PEND_CAN) begin
				r.nxt = L_CANCELLED; r.gate = 1'b1;
			end
			M_REJECT:     if (!is_terminal(cur)) begin
				r.nxt = L_REJECTED; r.gate = 1'b1;
			end
			M_EXPIRE:     if (is_active(cur)) begin
				r.nxt = L_EXPIRED; r.gate = 1'b1;
			end
			M_ERROR:      if (!is_terminal(cur)) begin
				r.nxt = L_ERROR; r.gate = 1'b1;
			end
			default:      r.gate = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ----- design/olt_entry_ram.sv -----
// slot entry memory: one write port, one registered read port
module olt_entry_ram (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [olt_pkg::SLOT_W-1:0] raddr,
	output olt_pkg::entry_t            rdata,
	input  logic                       we,
	input  logic [olt_pkg::SLOT_W-1:0] waddr,
	input  olt_pkg::entry_t            wdata
);

	olt_pkg::entry_t mem_q [olt_pkg::ORDER_SLOTS];
	olt_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/olt_update.sv -----
// per-item decision: lifecycle gate, transition check, timeouts and entry rewrite
module olt_update (
	input  olt_pkg::in_item_t item,
	input  logic              slot_ok,
	input  logic              used,
	input  olt_pkg::entry_t   entry,
	input  logic [31:0]       submit_default,
	input  logic [31:0]       cancel_default,
	output olt_pkg::upd_t     upd
);

	olt_pkg::mode_t   mode;
	olt_pkg::life_t   cur;
	olt_pkg::mode_t   evt;
	olt_pkg::ev_out_t evr;
	olt_pkg::status_t status;
	logic             has_ev;
	logic             tmo;
	logic [31:0]      elapsed;
	logic [32:0]      sub_sum;
	logic [32:0]      can_sum;
	logic [15:0]      amask;

	always_comb begin
		mode    = olt_pkg::mode_t'(item.mode);
		cur     = olt_pkg::life_t'(entry.life_state);
		elapsed = item.now_ms - entry.changed_at;
		sub_sum = 33'(entry.submit_limit) + 33'(item.extra_ms);
		can_sum = 33'(entry.cancel_limit) + 33'(item.extra_ms);
		evt     = olt_pkg::M_CREATE;
		has_ev  = 1'b0;
		tmo     = 1'b0;
		status  = olt_pkg::S_NOT_FOUND;
		evr     = olt_pkg::event_gate(cur, evt);
		amask   = '0;

		upd          = '0;
		upd.wentry   = entry;

		if (!slot_ok) begin
			status = olt_pkg::S_NOT_FOUND;
		end else if (mode == olt_pkg::M_CREATE) begin
			upd.we                  = 1'b1;
			upd.set_used            = 1'b1;
			upd.wentry.life_state   = olt_pkg::L_CREATED;
			upd.wentry.ordered_lots = item.lot_count;
			upd.wentry.filled_lots  = '0;
			upd.wentry.venue_order  = '0;
			upd.wentry.submit_limit = submit_default;
			upd.wentry.cancel_limit = cancel_default;
			upd.wentry.changed_at   = item.now_ms;
			status                  = olt_pkg::S_CHANGED;
		end else if (used) begin
			unique case (mode) inside
				olt_pkg::M_SUBMIT, olt_pkg::M_ACK, olt_pkg::M_PARTIAL, olt_pkg::M_FILL,
				olt_pkg::M_CANCEL_REQ, olt_pkg::M_CANCEL_CNF, olt_pkg::M_REJECT,
				olt_pkg::M_EXPIRE, olt_pkg::M_ERROR: begin
					has_ev = 1'b1;
					evt    = mode;
				end
				olt_pkg::M_FILL_UPD: begin
					upd.we                 = 1'b1;
					upd.wentry.filled_lots = item.lot_count;
					status                 = olt_pkg::S_NO_CHANGE;
					if (item.lot_count >= entry.ordered_lots) begin
						has_ev = 1'b1;
						evt    = olt_pkg::M_FILL;
					end else if (item.lot_count != '0) begin
						has_ev = 1'b1;
						evt    = olt_pkg::M_PARTIAL;
					end
				end
				olt_pkg::M_TIMEOUT: begin
					status = olt_pkg::S_NO_CHANGE;
					if (cur == olt_pkg::L_PEND_SUB && elapsed > entry.submit_limit) begin
						tmo    = 1'b1;
						has_ev = 1'b1;
						evt    = olt_pkg::M_EXPIRE;
					end else if (cur == olt_pkg::L_PEND_CAN &&
						elapsed > entry.cancel_limit) begin
						tmo    = 1'b1;
						has_ev = 1'b1;
						evt    = olt_pkg::M_ERROR;
					end
				end
				olt_pkg::M_EXTEND: begin
					status = olt_pkg::S_NO_CHANGE;
					// saturate at all ones on carry out
					if (cur == olt_pkg::L_PEND_SUB) begin
						upd.we                  = 1'b1;
						upd.wentry.submit_limit = sub_sum[32] ? '1 : sub_sum[31:0];
						status                  = olt_pkg::S_CHANGED;
					end else if (cur == olt_pkg::L_PEND_CAN) begin
						upd.we                  = 1'b1;
						upd.wentry.cancel_limit = can_sum[32] ? '1 : can_sum[31:0];
						status                  = olt_pkg::S_CHANGED;
					end
				end
				default: status = olt_pkg::S_REFUSED;
			endcase

			if (has_ev) begin
				evr   = olt_pkg::event_gate(cur, evt);
				amask = olt_pkg::allowed_mask(cur);
				if (!evr.gate) begin
					status = olt_pkg::S_NO_CHANGE;
				end else begin
					if (evt == olt_pkg::M_ACK && item.venue_id != '0) begin
						upd.we                 = 1'b1;
						upd.wentry.venue_order = item.venue_id;
					end
					if (!amask[evr.nxt]) begin
						status = olt_pkg::S_REFUSED;
					end else begin
						upd.we                = 1'b1;
						upd.wentry.life_state = evr.nxt;
						upd.wentry.changed_at = item.now_ms;
						status                = olt_pkg::S_CHANGED;
					end
				end
			end

			upd.res.state_before = cur;
			upd.res.state_after  = upd.wentry.life_state;
		end

		upd.res.status    = status;
		upd.res.ok        = (status == olt_pkg::S_CHANGED) || (status == olt_pkg::S_NO_CHANGE);
		upd.res.timed_out = tmo;
	end

endmodule

// ----- design/order_lifecycle_table.sv -----
// order lifecycle table top level: slot valid bits, config registers, read-modify-write control
//
//  channel | signals                          | transfer
//  --------+----------------------------------+-----------------------------------
//  item    | start, busy, item                | beat taken when start && !busy
//  result  | done, result                     | one-cycle strobe, cannot be held
//  config  | cfg_we, cfg_index, cfg_wdata     | written when cfg_we is high
//
// each item reads the entry memory on the accept edge; update and write-back follow in the
// busy cycle, whose closing edge also registers the result; done is high in the cycle in
// which busy has fallen back to 0, during which the next item may already be accepted.
// the entry memory read port is registered, so the update waits for the busy cycle.
// reset clears slot valid bits and loads both timeout defaults with 5000; no clearing pass.
// the receiver cannot stall, so results never back up.
module order_lifecycle_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  olt_pkg::in_item_t             item,
	output logic                          done,
	output olt_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [olt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [olt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic                         accept;
	logic [olt_pkg::SLOT_W-1:0]   idx;
	logic                         slot_ok;
	logic                         busy_q;
	logic                         done_q;
	olt_pkg::result_t             result_q;
	logic [olt_pkg::ORDER_SLOTS-1:0] used_q;
	logic [31:0]                  sub_def_q;
	logic [31:0]                  can_def_q;
	olt_pkg::in_item_t            item_s1;
	logic                         used_s1;
	logic                         slot_ok_s1;
	olt_pkg::entry_t              entry_rd;
	olt_pkg::upd_t                upd;

	assign accept  = start && !busy_q;
	assign idx     = item.slot[olt_pkg::SLOT_W-1:0];
	assign slot_ok = 32'(item.slot) < olt_pkg::ORDER_SLOTS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_def_q <= olt_pkg::SUBMIT_TIMEOUT_RESET;
			can_def_q <= olt_pkg::CANCEL_TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (olt_pkg::cfg_idx_t'(cfg_index))
				olt_pkg::CFG_SUBMIT_TIMEOUT: sub_def_q <= cfg_wdata;
				olt_pkg::CFG_CANCEL_TIMEOUT: can_def_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			used_q <= '0;
		end else begin
			done_q <= busy_q;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
			end
			if (busy_q && upd.set_used) begin
				used_q[item_s1.slot[olt_pkg::SLOT_W-1:0]] <= 1'b1;
			end
		end
	end

	// payload capture, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= item;
			used_s1    <= used_q[idx];
			slot_ok_s1 <= slot_ok;
		end
		if (busy_q) begin
			result_q <= upd.res;
		end
	end

	olt_entry_ram u_ram (
		.clk   (clk),
		.rd_en (accept),
		.raddr (idx),
		.rdata (entry_rd),
		.we    (busy_q && upd.we),
		.waddr (item_s1.slot[olt_pkg::SLOT_W-1:0]),
		.wdata (upd.wentry)
	);

	olt_update u_update (
		.item           (item_s1),
		.slot_ok        (slot_ok_s1),
		.used           (used_s1),
		.entry          (entry_rd),
		.submit_default (sub_def_q),
		.cancel_default (can_def_q),
		.upd            (upd)
	);

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- design/olt_checker.sv -----
// port-level checks for the order lifecycle table, bound to the top level
module olt_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input olt_pkg::result_t result
);

	// an accepted beat always occupies exactly one busy cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	a_done_follows_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without work");

	a_ok_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.ok == (result.status == olt_pkg::S_CHANGED ||
			result.status == olt_pkg::S_NO_CHANGE)))
		else $error("ok disagrees with status");

	a_not_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == olt_pkg::S_NOT_FOUND |->
			result.state_before == 4'd0 && result.state_after == 4'd0 && !result.timed_out)
		else $error("not-found result carries state");

endmodule

bind order_lifecycle_table olt_checker u_olt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
